// File: rtl/rdu_pkg.sv
// ----------------------------------------------------------------------------
// rdu_pkg
// Shared types and constants of the rational delta unit.
// ----------------------------------------------------------------------------
package rdu_pkg;

  localparam logic [29:0] MAG_LIMIT = 30'd1000000000;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NONINV = 2'd1,
    ST_WIDTH  = 2'd2
  } status_t;

  localparam logic [1:0] MODE_ADD = 2'd0;

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_STRICT = 2'd1;

  typedef struct packed {
    logic [1:0] mode;
    logic       strict;
  } cfg_t;

  // one classified request: magnitudes plus fraction signs
  typedef struct packed {
    status_t     status;
    logic        p_neg;
    logic [29:0] p_num;
    logic [29:0] p_den;
    logic        r_neg;
    logic [29:0] r_num;
    logic [29:0] r_den;
  } item_t;

endpackage

// File: rtl/rational_delta_unit_core.sv
// ----------------------------------------------------------------------------
// rational_delta_unit_core
// Exact ratio, additive and relative difference of two rational values.
// ----------------------------------------------------------------------------
// The time a request takes depends on the operands. At most, the back end runs
// six binary gcd reductions (one step per cycle) and thirteen divisions on one
// restoring divider at one quotient bit per cycle (a 30-bit dividend, but a
// 62-bit one for two of them), plus five multiplies on one combinational
// multiplier. A zero reference numerator that is an error stops after both
// fractions are reduced. Requests rejected at the front (zero denominator or
// out-of-range part) skip the back-end steps. Up to QUEUE_DEPTH requests wait
// in the front queue while the back end works, and one finished result waits
// in the result register.
module rational_delta_unit_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [30:0] in_projected_num,
  input  logic signed [30:0] in_projected_den,
  input  logic signed [30:0] in_reference_num,
  input  logic signed [30:0] in_reference_den,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_status,
  output logic signed [30:0] out_proj_red_num,
  output logic [29:0]        out_proj_red_den,
  output logic signed [30:0] out_ref_red_num,
  output logic [29:0]        out_ref_red_den,
  output logic signed [60:0] out_ratio_num,
  output logic [59:0]        out_ratio_den,
  output logic signed [61:0] out_add_num,
  output logic [59:0]        out_add_den,
  output logic signed [31:0] out_rel_num,
  output logic [29:0]        out_rel_den,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [1:0]         cfg_data
);

  rdu_pkg::cfg_t  cfg_r;
  rdu_pkg::item_t front_item, q_item;
  logic           q_empty, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rdu_pkg::CFG_MODE:   cfg_r.mode   <= cfg_data;
        rdu_pkg::CFG_STRICT: cfg_r.strict <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rdu_front u_front (
    .projected_num (in_projected_num),
    .projected_den (in_projected_den),
    .reference_num (in_reference_num),
    .reference_den (in_reference_den),
    .item          (front_item)
  );

  rdu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (front_item),
    .full  (in_full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

  rdu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_proj_red_num (out_proj_red_num),
    .out_proj_red_den (out_proj_red_den),
    .out_ref_red_num  (out_ref_red_num),
    .out_ref_red_den  (out_ref_red_den),
    .out_ratio_num    (out_ratio_num),
    .out_ratio_den    (out_ratio_den),
    .out_add_num      (out_add_num),
    .out_add_den      (out_add_den),
    .out_rel_num      (out_rel_num),
    .out_rel_den      (out_rel_den)
  );

endmodule

// File: rtl/rdu_front.sv
// ----------------------------------------------------------------------------
// rdu_front
// Classifies an incoming request: range and zero-denominator checks,
// splits each fraction into magnitudes and a sign.
// ----------------------------------------------------------------------------
module rdu_front (
  input  logic signed [30:0] projected_num,
  input  logic signed [30:0] projected_den,
  input  logic signed [30:0] reference_num,
  input  logic signed [30:0] reference_den,
  output rdu_pkg::item_t     item
);

  function automatic logic [30:0] mag31(input logic [30:0] v);
    mag31 = v[30] ? 31'(~v + 31'd1) : v;
  endfunction

  logic [30:0] pn_m, pd_m, rn_m, rd_m;
  logic        p_over, r_over;

  assign pn_m = mag31(projected_num);
  assign pd_m = mag31(projected_den);
  assign rn_m = mag31(reference_num);
  assign rd_m = mag31(reference_den);

  assign p_over = (pn_m > {1'b0, rdu_pkg::MAG_LIMIT}) || (pd_m > {1'b0, rdu_pkg::MAG_LIMIT});
  assign r_over = (rn_m > {1'b0, rdu_pkg::MAG_LIMIT}) || (rd_m > {1'b0, rdu_pkg::MAG_LIMIT});

  always_comb begin
    if (pd_m == 31'd0) begin
      item.status = rdu_pkg::ST_NONINV;
    end else if (p_over) begin
      item.status = rdu_pkg::ST_WIDTH;
    end else if (rd_m == 31'd0) begin
      item.status = rdu_pkg::ST_NONINV;
    end else if (r_over) begin
      item.status = rdu_pkg::ST_WIDTH;
    end else begin
      item.status = rdu_pkg::ST_OK;
    end
    item.p_neg = projected_num[30] ^ projected_den[30];
    item.p_num = pn_m[29:0];
    item.p_den = pd_m[29:0];
    item.r_neg = reference_num[30] ^ reference_den[30];
    item.r_num = rn_m[29:0];
    item.r_den = rd_m[29:0];
  end

endmodule

// File: rtl/rdu_fifo.sv
// ----------------------------------------------------------------------------
// rdu_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module rdu_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rdu_pkg::item_t din,
  output logic           full,
  input  logic           pop,
  output rdu_pkg::item_t dout,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rdu_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0]  wptr_r, rptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : AW'(wptr_r + 1'b1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : AW'(rptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= CW'(cnt_r + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_r <= CW'(cnt_r - 1'b1);
      end
    end
  end

endmodule

// File: rtl/rdu_gcd.sv
// ----------------------------------------------------------------------------
// rdu_gcd
// Binary gcd of two 30-bit magnitudes, one step per cycle.
// gcd(0,0) is reported as 1.
// ----------------------------------------------------------------------------
module rdu_gcd (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [29:0] a,
  input  logic [29:0] b,
  output logic        done,
  output logic [29:0] result
);

  logic        run_r, done_r;
  logic [29:0] a_r, b_r, res_r;
  logic [4:0]  k_r;

  assign done   = done_r;
  assign result = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r   <= a;
        b_r   <= b;
        k_r   <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (a_r == '0 || b_r == '0) begin
          res_r  <= ((a_r | b_r) == '0) ? 30'd1 : 30'((a_r | b_r) << k_r);
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else if (!a_r[0] && !b_r[0]) begin
          a_r <= a_r >> 1;
          b_r <= b_r >> 1;
          k_r <= 5'(k_r + 1'b1);
        end else if (!a_r[0]) begin
          a_r <= a_r >> 1;
        end else if (!b_r[0]) begin
          b_r <= b_r >> 1;
        end else if (a_r >= b_r) begin
          a_r <= 30'(a_r - b_r) >> 1;
        end else begin
          b_r <= 30'(b_r - a_r) >> 1;
        end
      end
    end
  end

endmodule

// File: rtl/rdu_div.sv
// ----------------------------------------------------------------------------
// rdu_div
// Restoring divider, one quotient bit per cycle. Long requests take a
// 62-bit dividend, short ones a 30-bit dividend; the divisor is 30 bits.
// ----------------------------------------------------------------------------
module rdu_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        long_op,
  input  logic [61:0] dividend,
  input  logic [29:0] divisor,
  output logic        done,
  output logic [61:0] quot,
  output logic [29:0] rem
);

  logic        run_r, done_r;
  logic [5:0]  cnt_r;
  logic [61:0] dq_r;
  logic [29:0] rm_r, dv_r;
  logic [30:0] trial;
  logic        ge;

  assign trial = {rm_r, dq_r[61]};
  assign ge    = trial >= {1'b0, dv_r};
  assign done  = done_r;
  assign quot  = dq_r;
  assign rem   = rm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dq_r  <= long_op ? dividend : {dividend[29:0], 32'd0};
        cnt_r <= long_op ? 6'd62 : 6'd30;
        rm_r  <= '0;
        dv_r  <= divisor;
        run_r <= 1'b1;
      end else if (run_r) begin
        rm_r  <= ge ? 30'(trial - {1'b0, dv_r}) : trial[29:0];
        dq_r  <= {dq_r[60:0], ge};
        cnt_r <= 6'(cnt_r - 1'b1);
        if (cnt_r == 6'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/rdu_back.sv
// ----------------------------------------------------------------------------
// rdu_back
// Sequencer that reduces both fractions and forms ratio, additive and
// relative differences with a shared gcd unit, divider and multiplier.
// ----------------------------------------------------------------------------
module rdu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rdu_pkg::cfg_t       cfg,
  input  logic                q_empty,
  input  rdu_pkg::item_t      q_item,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [1:0]          out_status,
  output logic signed [30:0]  out_proj_red_num,
  output logic [29:0]         out_proj_red_den,
  output logic signed [30:0]  out_ref_red_num,
  output logic [29:0]         out_ref_red_den,
  output logic signed [60:0]  out_ratio_num,
  output logic [59:0]         out_ratio_den,
  output logic signed [61:0]  out_add_num,
  output logic [59:0]         out_add_den,
  output logic signed [31:0]  out_rel_num,
  output logic [29:0]         out_rel_den
);

  typedef enum logic [28:0] {
    S_IDLE  = 29'b1 << 0,
    S_G_P   = 29'b1 << 1,
    S_D_PN  = 29'b1 << 2,
    S_D_PD  = 29'b1 << 3,
    S_G_R   = 29'b1 << 4,
    S_D_RN  = 29'b1 << 5,
    S_D_RD  = 29'b1 << 6,
    S_CHK   = 29'b1 << 7,
    S_G_Q1  = 29'b1 << 8,
    S_G_Q2  = 29'b1 << 9,
    S_D_QA  = 29'b1 << 10,
    S_D_QB  = 29'b1 << 11,
    S_D_QC  = 29'b1 << 12,
    S_D_QE  = 29'b1 << 13,
    S_M_QN  = 29'b1 << 14,
    S_M_QD  = 29'b1 << 15,
    S_CHKQ  = 29'b1 << 16,
    S_G_A   = 29'b1 << 17,
    S_D_AX  = 29'b1 << 18,
    S_D_AY  = 29'b1 << 19,
    S_M_A1  = 29'b1 << 20,
    S_M_A2  = 29'b1 << 21,
    S_T_SUB = 29'b1 << 22,
    S_D_AR  = 29'b1 << 23,
    S_G_A2  = 29'b1 << 24,
    S_D_AN  = 29'b1 << 25,
    S_D_AZ  = 29'b1 << 26,
    S_M_AD  = 29'b1 << 27,
    S_FIN   = 29'b1 << 28
  } state_t;

  state_t           state_r, state_nxt;
  rdu_pkg::status_t st_r;
  logic             issued_r, out_valid_r;
  logic             np_r, nr_r, tneg_r;
  logic [29:0]      pn_r, pd_r, rn_r, rd_r, g_r, h_r, u_r, v_r, w_r, x_r;
  logic [59:0]      qn_r, qd_r, m_r, n_r, ad_r;
  logic [60:0]      tm_r;

  logic        is_gcd, is_div, is_mul, adv, out_free;
  logic        gcd_start, gcd_done, div_start, div_done, div_long;
  logic [29:0] gcd_a, gcd_b, gcd_res, div_dvs, div_rem, mul_a, mul_b;
  logic [61:0] div_dvd, div_quot;
  logic [59:0] prod;
  logic        same_sgn, m_lt;
  logic [60:0] t_mag;
  logic        q_over;

  assign is_gcd = (state_r == S_G_P) || (state_r == S_G_R) || (state_r == S_G_Q1) ||
                  (state_r == S_G_Q2) || (state_r == S_G_A) || (state_r == S_G_A2);
  assign is_div = (state_r == S_D_PN) || (state_r == S_D_PD) || (state_r == S_D_RN) ||
                  (state_r == S_D_RD) || (state_r == S_D_QA) || (state_r == S_D_QB) ||
                  (state_r == S_D_QC) || (state_r == S_D_QE) || (state_r == S_D_AX) ||
                  (state_r == S_D_AY) || (state_r == S_D_AR) || (state_r == S_D_AN) ||
                  (state_r == S_D_AZ);
  assign is_mul = (state_r == S_M_QN) || (state_r == S_M_QD) || (state_r == S_M_A1) ||
                  (state_r == S_M_A2) || (state_r == S_M_AD);

  assign gcd_start = is_gcd && !issued_r;
  assign div_start = is_div && !issued_r;
  assign adv       = is_gcd ? gcd_done : (is_div ? div_done : 1'b1);
  assign out_free  = !out_valid_r || out_pop;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;

  rdu_gcd u_gcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (gcd_start),
    .a      (gcd_a),
    .b      (gcd_b),
    .done   (gcd_done),
    .result (gcd_res)
  );

  rdu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .long_op  (div_long),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // operand selection
  always_comb begin
    gcd_a    = pn_r;
    gcd_b    = pd_r;
    div_dvd  = 62'(pn_r);
    div_dvs  = g_r;
    div_long = 1'b0;
    mul_a    = u_r;
    mul_b    = v_r;
    case (state_r)
      S_G_R:  begin gcd_a = rn_r; gcd_b = rd_r; end
      S_G_Q1: begin gcd_a = pn_r; gcd_b = rn_r; end
      S_G_Q2: begin gcd_a = pd_r; gcd_b = rd_r; end
      S_G_A:  begin gcd_a = pd_r; gcd_b = rd_r; end
      S_G_A2: begin gcd_a = x_r;  gcd_b = g_r;  end
      S_D_PD: div_dvd = 62'(pd_r);
      S_D_RN: div_dvd = 62'(rn_r);
      S_D_RD: div_dvd = 62'(rd_r);
      S_D_QB: begin div_dvd = 62'(rd_r); div_dvs = h_r; end
      S_D_QC: begin div_dvd = 62'(pd_r); div_dvs = h_r; end
      S_D_QE: div_dvd = 62'(rn_r);
      S_D_AX: div_dvd = 62'(rd_r);
      S_D_AY: div_dvd = 62'(pd_r);
      S_D_AR: begin div_dvd = {1'b0, tm_r}; div_long = 1'b1; end
      S_D_AN: begin div_dvd = {1'b0, tm_r}; div_dvs = h_r; div_long = 1'b1; end
      S_D_AZ: begin div_dvd = 62'(rd_r); div_dvs = h_r; end
      S_M_QD: begin mul_a = w_r;  mul_b = x_r; end
      S_M_A1: begin mul_a = pn_r; mul_b = u_r; end
      S_M_A2: begin mul_a = rn_r; mul_b = v_r; end
      S_M_AD: begin mul_a = v_r;  mul_b = w_r; end
      default: ;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign same_sgn = (np_r == nr_r);
  assign m_lt     = m_r < n_r;
  assign t_mag    = same_sgn ? (m_lt ? 61'(n_r - m_r) : 61'(m_r - n_r))
                             : 61'({1'b0, m_r} + {1'b0, n_r});
  assign q_over   = (qn_r > 60'(rdu_pkg::MAG_LIMIT)) || (qd_r > 60'(rdu_pkg::MAG_LIMIT));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (!q_empty) state_nxt = (q_item.status == rdu_pkg::ST_OK) ? S_G_P : S_FIN;
      S_G_P:   if (adv) state_nxt = S_D_PN;
      S_D_PN:  if (adv) state_nxt = S_D_PD;
      S_D_PD:  if (adv) state_nxt = S_G_R;
      S_G_R:   if (adv) state_nxt = S_D_RN;
      S_D_RN:  if (adv) state_nxt = S_D_RD;
      S_D_RD:  if (adv) state_nxt = S_CHK;
      S_CHK: begin
        if (rn_r != '0) begin
          state_nxt = S_G_Q1;
        end else if (cfg.mode != rdu_pkg::MODE_ADD || cfg.strict) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_G_A;
        end
      end
      S_G_Q1:  if (adv) state_nxt = S_G_Q2;
      S_G_Q2:  if (adv) state_nxt = S_D_QA;
      S_D_QA:  if (adv) state_nxt = S_D_QB;
      S_D_QB:  if (adv) state_nxt = S_D_QC;
      S_D_QC:  if (adv) state_nxt = S_D_QE;
      S_D_QE:  if (adv) state_nxt = S_M_QN;
      S_M_QN:  state_nxt = S_M_QD;
      S_M_QD:  state_nxt = S_CHKQ;
      S_CHKQ:  state_nxt = q_over ? S_FIN : S_G_A;
      S_G_A:   if (adv) state_nxt = S_D_AX;
      S_D_AX:  if (adv) state_nxt = S_D_AY;
      S_D_AY:  if (adv) state_nxt = S_M_A1;
      S_M_A1:  state_nxt = S_M_A2;
      S_M_A2:  state_nxt = S_T_SUB;
      S_T_SUB: state_nxt = (t_mag == '0) ? S_FIN : S_D_AR;
      S_D_AR:  if (adv) state_nxt = S_G_A2;
      S_G_A2:  if (adv) state_nxt = S_D_AN;
      S_D_AN:  if (adv) state_nxt = S_D_AZ;
      S_D_AZ:  if (adv) state_nxt = S_M_AD;
      S_M_AD:  state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((is_gcd || is_div) && !issued_r) begin
        issued_r <= 1'b1;
      end else if (adv) begin
        issued_r <= 1'b0;
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        st_r <= q_item.status;
        np_r <= q_item.p_neg;
        nr_r <= q_item.r_neg;
        pn_r <= q_item.p_num;
        pd_r <= q_item.p_den;
        rn_r <= q_item.r_num;
        rd_r <= q_item.r_den;
        qn_r <= '0;
        qd_r <= 60'd1;
      end
      S_G_P, S_G_R, S_G_Q1, S_G_A: if (adv) g_r <= gcd_res;
      S_G_Q2, S_G_A2: if (adv) h_r <= gcd_res;
      S_D_PN: if (adv) pn_r <= div_quot[29:0];
      S_D_PD: if (adv) pd_r <= div_quot[29:0];
      S_D_RN: if (adv) rn_r <= div_quot[29:0];
      S_D_RD: if (adv) rd_r <= div_quot[29:0];
      S_CHK: if (rn_r == '0 && (cfg.mode != rdu_pkg::MODE_ADD || cfg.strict)) begin
        st_r <= rdu_pkg::ST_NONINV;
      end
      S_D_QA, S_D_AX: if (adv) u_r <= div_quot[29:0];
      S_D_QB, S_D_AY: if (adv) v_r <= div_quot[29:0];
      S_D_QC, S_D_AZ: if (adv) w_r <= div_quot[29:0];
      S_D_QE: if (adv) x_r <= div_quot[29:0];
      S_D_AR: if (adv) x_r <= div_rem;
      S_D_AN: if (adv) tm_r <= div_quot[60:0];
      S_M_QN: qn_r <= prod;
      S_M_QD: qd_r <= prod;
      S_CHKQ: if (q_over) st_r <= rdu_pkg::ST_WIDTH;
      S_M_A1: m_r <= prod;
      S_M_A2: n_r <= prod;
      S_T_SUB: begin
        tm_r   <= t_mag;
        tneg_r <= same_sgn ? (np_r ^ m_lt) : np_r;
        ad_r   <= 60'd1;
      end
      S_M_AD: ad_r <= prod;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_status <= st_r;
      if (st_r == rdu_pkg::ST_OK) begin
        out_proj_red_num <= np_r ? -$signed({1'b0, pn_r}) : $signed({1'b0, pn_r});
        out_proj_red_den <= pd_r;
        out_ref_red_num  <= nr_r ? -$signed({1'b0, rn_r}) : $signed({1'b0, rn_r});
        out_ref_red_den  <= rd_r;
        out_ratio_num    <= (np_r ^ nr_r) ? -$signed({1'b0, qn_r}) : $signed({1'b0, qn_r});
        out_ratio_den    <= qd_r;
        out_add_num      <= tneg_r ? -$signed({1'b0, tm_r}) : $signed({1'b0, tm_r});
        out_add_den      <= ad_r;
        out_rel_num      <= ((np_r ^ nr_r) ? -$signed({2'b0, qn_r[29:0]})
                                           : $signed({2'b0, qn_r[29:0]}))
                            - $signed({2'b0, qd_r[29:0]});
        out_rel_den      <= qd_r[29:0];
      end else begin
        out_proj_red_num <= '0;
        out_proj_red_den <= '0;
        out_ref_red_num  <= '0;
        out_ref_red_den  <= '0;
        out_ratio_num    <= '0;
        out_ratio_den    <= '0;
        out_add_num      <= '0;
        out_add_den      <= '0;
        out_rel_num      <= '0;
        out_rel_den      <= '0;
      end
    end
  end

endmodule

// File: test/rational_delta_unit_core_tb.sv
// ----------------------------------------------------------------------------
// rational_delta_unit_core_tb
// Self-checking bench: random and directed fraction pairs, every mode and
// strict setting, random stalls on both sides and one long result hold-off.
// Each result is checked field by field against an in-bench predictor.
// ----------------------------------------------------------------------------
module rational_delta_unit_core_tb;

  localparam logic [1:0] MODE_RATIO = 2'd1;
  localparam logic [1:0] MODE_REL   = 2'd2;
  localparam logic [1:0] MODE_ALL   = 2'd3;
  localparam logic [1:0] CFG_SPARE  = 2'd3;
  localparam longint     BOUND      = 64'sd1000000000;

  typedef struct {
    rdu_pkg::status_t       st;
    logic signed [30:0]     prn;
    logic [29:0]            prd;
    logic signed [30:0]     rrn;
    logic [29:0]            rrd;
    logic signed [60:0]     qn;
    logic [59:0]            qd;
    logic signed [61:0]     an;
    logic [59:0]            ad;
    logic signed [31:0]     ln;
    logic [29:0]            ld;
  } delta_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic signed [30:0] in_projected_num = '0;
  logic signed [30:0] in_projected_den = '0;
  logic signed [30:0] in_reference_num = '0;
  logic signed [30:0] in_reference_den = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [1:0]         out_status;
  logic signed [30:0] out_proj_red_num;
  logic [29:0]        out_proj_red_den;
  logic signed [30:0] out_ref_red_num;
  logic [29:0]        out_ref_red_den;
  logic signed [60:0] out_ratio_num;
  logic [59:0]        out_ratio_den;
  logic signed [61:0] out_add_num;
  logic [59:0]        out_add_den;
  logic signed [31:0] out_rel_num;
  logic [29:0]        out_rel_den;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [1:0]         cfg_data = '0;

  delta_t     delta_q[$];
  logic [1:0] mode_r = rdu_pkg::MODE_ADD;
  logic       strict_r = 1'b0;
  int         errors = 0;
  bit         idle_on = 1'b1;
  int         rx_hold = 0;

  rational_delta_unit_core dut (.*);

  always #5 clk = ~clk;

  function automatic longint abs64(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit over_bound(input longint a, input longint b);
    return abs64(a) > BOUND || abs64(b) > BOUND;
  endfunction

  function automatic longint gcd64(input longint a, input longint b);
    longint t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a != 0 ? a : 1;
  endfunction

  function automatic void reduce_frac(input longint n, input longint d,
                                      output longint on, output longint od);
    bit     neg;
    longint un, ud, g;
    neg = (n < 0) != (d < 0);
    un = abs64(n);
    ud = abs64(d);
    g = gcd64(un, ud);
    un = un / g;
    ud = ud / g;
    on = neg ? -un : un;
    od = ud;
  endfunction

  function automatic delta_t predict_delta(input logic signed [30:0] a, b, c, d);
    longint pn, pd, rn, rd, prn, prd, rrn, rrd, qn, qd, an, ad, ln, ld;
    delta_t r;
    pn = a; pd = b; rn = c; rd = d;
    r.st = rdu_pkg::ST_OK;
    r.prn = '0; r.prd = '0; r.rrn = '0; r.rrd = '0; r.qn = '0;
    r.qd = '0; r.an = '0; r.ad = '0; r.ln = '0; r.ld = '0;
    if (pd == 0) r.st = rdu_pkg::ST_NONINV;
    else if (over_bound(pn, pd)) r.st = rdu_pkg::ST_WIDTH;
    else if (rd == 0) r.st = rdu_pkg::ST_NONINV;
    else if (over_bound(rn, rd)) r.st = rdu_pkg::ST_WIDTH;
    if (r.st == rdu_pkg::ST_OK) begin
      reduce_frac(pn, pd, prn, prd);
      reduce_frac(rn, rd, rrn, rrd);
      if (rrn == 0) begin
        if (mode_r != rdu_pkg::MODE_ADD || strict_r) r.st = rdu_pkg::ST_NONINV;
        qn = 0;
        qd = 1;
      end else begin
        reduce_frac(prn * rrd, prd * rrn, qn, qd);
      end
    end
    if (r.st == rdu_pkg::ST_OK) begin
      reduce_frac(prn * rrd - rrn * prd, prd * rrd, an, ad);
      if (over_bound(qn, qd)) r.st = rdu_pkg::ST_WIDTH;
      else reduce_frac(qn - qd, qd, ln, ld);
    end
    if (r.st == rdu_pkg::ST_OK) begin
      r.prn = prn[30:0]; r.prd = prd[29:0];
      r.rrn = rrn[30:0]; r.rrd = rrd[29:0];
      r.qn = qn[60:0];   r.qd = qd[59:0];
      r.an = an[61:0];   r.ad = ad[59:0];
      r.ln = ln[31:0];   r.ld = ld[29:0];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // result side: pop with random stalls, compare at the falling edge
  initial begin
    int     burst;
    delta_t e;
    burst = 0;
    forever begin
      @(negedge clk);
      if (out_pop && !out_empty) begin
        if (delta_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result, status %0d", $time, out_status);
        end else begin
          e = delta_q.pop_front();
          check_field("status", 64'(e.st), 64'(out_status));
          check_field("proj_red_num", 64'(e.prn), 64'(out_proj_red_num));
          check_field("proj_red_den", 64'(e.prd), 64'(out_proj_red_den));
          check_field("ref_red_num", 64'(e.rrn), 64'(out_ref_red_num));
          check_field("ref_red_den", 64'(e.rrd), 64'(out_ref_red_den));
          check_field("ratio_num", 64'(e.qn), 64'(out_ratio_num));
          check_field("ratio_den", 64'(e.qd), 64'(out_ratio_den));
          check_field("add_num", 64'(e.an), 64'(out_add_num));
          check_field("add_den", 64'(e.ad), 64'(out_add_den));
          check_field("rel_num", 64'(e.ln), 64'(out_rel_num));
          check_field("rel_den", 64'(e.ld), 64'(out_rel_den));
        end
      end
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_pop <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 18) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic send_frac(input logic signed [30:0] a, b, c, d);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_projected_num <= a;
    in_projected_den <= b;
    in_reference_num <= c;
    in_reference_den <= d;
    forever begin
      @(negedge clk);
      if (!in_full) break;
      @(posedge clk);
    end
    delta_q.push_back(predict_delta(a, b, c, d));
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    in_push <= 1'b0;
    while (delta_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
      @(posedge clk);
    end
    if (idx == rdu_pkg::CFG_MODE) mode_r = val;
    else if (idx == rdu_pkg::CFG_STRICT) strict_r = val[0];
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [30:0] rand_part(input bit nonzero);
    logic signed [30:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = 31'($urandom_range(0, 24));
      3, 4:    v = 31'($urandom_range(1, 5000) * $urandom_range(1, 3000));
      5, 6:    v = 31'($urandom_range(0, 1000000000));
      7:       v = 31'($urandom_range(1, 40) * 27720);
      8:       v = 31'($urandom_range(999999000, 1000000000));
      default: v = 31'($urandom_range(1, 1 << 15) << $urandom_range(0, 14));
    endcase
    if (v > 31'sd1000000000) v = 31'sd1000000000;
    if (nonzero && v == 0) v = 31'sd1;
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic send_random(input int count);
    logic signed [30:0] f[4];
    for (int i = 0; i < count; i++) begin
      f[0] = rand_part(0);
      f[1] = rand_part(1);
      f[2] = rand_part(0);
      f[3] = rand_part(1);
      if ($urandom_range(0, 3) == 0) f[0] = f[2] * 31'($urandom_range(1, 3));
      case ($urandom_range(0, 19))
        0: f[$urandom_range(0, 3)] = 31'($urandom);
        1: f[1 + 2 * $urandom_range(0, 1)] = '0;
        default: ;
      endcase
      send_frac(f[0], f[1], f[2], f[3]);
    end
  endtask

  task automatic test_directed;
    send_frac(31'sd6, 31'sd4, 31'sd3, 31'sd9);
    send_frac(-31'sd6, -31'sd4, 31'sd3, -31'sd9);
    send_frac(31'sd1000000000, 31'sd1, -31'sd1000000000, 31'sd1);
    send_frac(-31'sd1000000000, 31'sd999999999, 31'sd1, 31'sd1000000000);
    send_frac(31'sd1, 31'sd1000000000, 31'sd1000000000, 31'sd1);
    send_frac(31'sd0, 31'sd7, 31'sd5, 31'sd3);
    send_frac(31'sd5, 31'sd3, 31'sd0, 31'sd7);
    send_frac(31'sd5, 31'sd0, 31'sd3, 31'sd2);
    send_frac(31'sd5, 31'sd2, 31'sd3, 31'sd0);
    send_frac(31'sd5, 31'sd0, 31'sd3, 31'sd0);
    send_frac(31'sd1000000001, 31'sd0, 31'sd1, 31'sd1);
    send_frac(31'sd1000000001, 31'sd1, 31'sd1, 31'sd0);
    send_frac(31'sd1, 31'sd1, 31'sd1, 31'sd0);
    send_frac(31'sd1, 31'sd1, -31'sd1073741824, 31'sd1);
    send_frac(31'sd1073741823, -31'sd1073741824, 31'sd1, 31'sd1);
    send_frac(31'sd1, 31'sd1, 31'sd1, 31'sd1073741823);
    send_frac(31'sd7, 31'sd7, 31'sd7, 31'sd7);
    send_frac(31'sd0, -31'sd3, 31'sd0, 31'sd5);
    send_frac(31'sd999999937, 31'sd1, 31'sd1, 31'sd999999929);
    send_frac(31'sd3, 31'sd1, 31'sd1, 31'sd1000000000);
  endtask

  task automatic test_modes;
    logic [1:0] m;
    for (int k = 0; k < 8; k++) begin
      m = k[1:0];
      write_reg(rdu_pkg::CFG_MODE, m);
      write_reg(rdu_pkg::CFG_STRICT, {1'b0, k[2]});
      test_directed();
      send_random(80);
    end
    write_reg(CFG_SPARE, 2'd3);
    write_reg(rdu_pkg::CFG_STRICT, 2'd2);
    send_random(40);
  endtask

  task automatic test_backpressure;
    write_reg(rdu_pkg::CFG_MODE, MODE_ALL);
    rx_hold = 3000;
    send_frac(31'sd0, 31'sd1, 31'sd1, 31'sd1);
    send_frac(31'sd5, 31'sd0, 31'sd1, 31'sd1);
    send_random(10);
  endtask

  task automatic test_streaming;
    idle_on = 1'b0;
    write_reg(rdu_pkg::CFG_MODE, MODE_REL);
    write_reg(rdu_pkg::CFG_STRICT, 2'd0);
    send_random(200);
    in_push <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_modes();
    test_backpressure();
    write_reg(rdu_pkg::CFG_MODE, MODE_RATIO);
    send_random(30);
    test_streaming();
    while (delta_q.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (errors == 0) begin
      $display("rational_delta_unit_core_tb: PASS");
    end else begin
      $display("rational_delta_unit_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("rational_delta_unit_core_tb: FAIL");
    $finish;
  end

endmodule
